[design/glob_pattern_stream_matcher_unit_defines.svh]
// Assertion macros shared by the checker
`ifndef GLOB_PATTERN_STREAM_MATCHER_UNIT_DEFINES_SVH
`define GLOB_PATTERN_STREAM_MATCHER_UNIT_DEFINES_SVH
// Implication checked on every rising clock edge, reset disables
`define GPSM_ASSERT_IMP(label, clk, rst, cond, prop, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (cond) |-> (prop)) else $error(msg);
// Next-cycle implication
`define GPSM_ASSERT_NXT(label, clk, rst, cond, prop, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (cond) |=> (prop)) else $error(msg);
`endif

[design/gpsm_pkg.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// gpsm_pkg
// Shared constants and control/status types of the glob stream matcher.
// ----------------------------------------------------------------------------
package gpsm_pkg;
   localparam int PATTERN_MAX = 32;
   localparam int POS_W = $clog2(PATTERN_MAX + 2);
   localparam int IDX_W = $clog2(PATTERN_MAX);

   localparam logic [7:0] CH_ESC  = 8'h5C;
   localparam logic [7:0] CH_STAR = 8'h2A;
   localparam logic [7:0] CH_DOT  = 8'h2E;

   // register indexes
   localparam logic [2:0] REG_MODE = 3'd0;
   localparam logic [2:0] REG_LEN  = 3'd1;
   localparam logic [2:0] REG_W0   = 3'd2;
   localparam logic [2:0] REG_W1   = 3'd3;
   localparam logic [2:0] REG_W2   = 3'd4;
   localparam logic [2:0] REG_W3   = 3'd5;

   // match modes
   localparam logic [1:0] MODE_LITERAL = 2'd0;
   localparam logic [1:0] MODE_PREFIX  = 2'd1;
   localparam logic [1:0] MODE_SUFFIX  = 2'd2;
   localparam logic [1:0] MODE_GLOB    = 2'd3;

   // glob phases
   localparam logic [1:0] PH_NORMAL = 2'd0;
   localparam logic [1:0] PH_RUN    = 2'd1;
   localparam logic [1:0] PH_SCAN   = 2'd2;

   typedef struct packed {
      logic load;     // capture byte, update literal/suffix trackers
      logic glob_go;  // run one glob pattern step
      logic finish;   // compute verdict and clear per-string state
   } gpsm_cmd_type;

   typedef struct packed {
      logic glob_busy; // glob walk needs another step
   } gpsm_sts_type;
endpackage

[design/gpsm_datapath.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// gpsm_datapath
// Pattern registers, literal/prefix/suffix trackers and the glob step unit.
// ----------------------------------------------------------------------------
module gpsm_datapath import gpsm_pkg::*; (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  csr_we,
   input  logic [2:0]            csr_index,
   input  logic [63:0]           csr_data,
   input  logic [7:0]            in_byte,
   input  logic                  in_has,
   input  gpsm_cmd_type          cmd,
   output gpsm_sts_type          sts,
   output logic                  verdict
);
   logic [1:0]  mode_ff;
   logic [5:0]  len_ff;
   logic [63:0] word_ff [4];

   logic [POS_W-1:0] pos_ff, pos_in;
   logic [1:0]  phase_ff, phase_in;
   logic [7:0]  run_ff, run_in;
   logic        done_ff, done_in, val_ff, val_in;
   logic [POS_W-1:0] seen_ff;
   logic        eq_ff;
   logic [7:0]  recent_ff [PATTERN_MAX];
   logic [7:0]  byte_ff;
   logic        busy_ff, busy_in;

   logic [POS_W-1:0] n;
   assign n = (len_ff > 6'(PATTERN_MAX)) ? POS_W'(PATTERN_MAX) : POS_W'(len_ff);

   function automatic logic [7:0] pbyte(input logic [63:0] w [4], input logic [POS_W:0] i);
      logic [7:0] r;
      r = 8'd0;
      if (i < (POS_W+1)'(PATTERN_MAX))
         r = w[i[4:3]][{i[2:0], 3'b000} +: 8];
      return r;
   endfunction

   // configuration
   always_ff @(posedge clock) begin
      if (reset) begin
         mode_ff <= MODE_LITERAL;
         len_ff  <= '0;
         for (int k = 0; k < 4; k++) word_ff[k] <= '0;
      end else if (csr_we) begin
         unique case (csr_index)
            REG_MODE: mode_ff <= csr_data[1:0];
            REG_LEN:  len_ff  <= csr_data[5:0];
            REG_W0:   word_ff[0] <= csr_data;
            REG_W1:   word_ff[1] <= csr_data;
            REG_W2:   word_ff[2] <= csr_data;
            REG_W3:   word_ff[3] <= csr_data;
            default: ;
         endcase
      end
   end

   // one glob step: consume escape / star run, or settle the byte
   logic [POS_W:0] ip, ip2;
   logic [7:0] c, nx, t;
   logic esc;
   always_comb begin
      pos_in = pos_ff; phase_in = phase_ff; run_in = run_ff;
      done_in = done_ff; val_in = val_ff; busy_in = 1'b0;
      ip = (POS_W+1)'(pos_ff) + 1'b1;
      c = pbyte(word_ff, (POS_W+1)'(pos_ff));
      esc = (c == CH_ESC);
      ip2 = esc ? ip + 1'b1 : ip;
      if (esc) c = (ip < (POS_W+1)'(n)) ? pbyte(word_ff, ip) : 8'd0;
      nx = (ip2 < (POS_W+1)'(n)) ? pbyte(word_ff, ip2) : 8'd0;
      t = pbyte(word_ff, ip2 + 1'b1);
      if (cmd.glob_go && !done_ff) begin
         if (!busy_ff && phase_ff == PH_RUN && byte_ff == run_ff) begin
            // stays in run
         end else if (!busy_ff && phase_ff == PH_SCAN) begin
            if (byte_ff == run_ff) phase_in = PH_NORMAL;
         end else if ((POS_W+1)'(pos_ff) >= (POS_W+1)'(n)) begin
            done_in = 1'b1; val_in = 1'b0; phase_in = PH_NORMAL;
         end else if (nx == CH_STAR && !esc && c == CH_DOT) begin
            if (ip2 + 1'b1 >= (POS_W+1)'(n)) begin
               done_in = 1'b1; val_in = 1'b1; phase_in = PH_NORMAL;
            end else if (t == CH_ESC) begin
               t = (ip2 + 2'd2 < (POS_W+1)'(n)) ? pbyte(word_ff, ip2 + 2'd2) : 8'd0;
               pos_in = POS_W'(ip2 + 2'd3);
               run_in = t;
               phase_in = (byte_ff == t) ? PH_NORMAL : PH_SCAN;
            end else begin
               pos_in = POS_W'(ip2 + 2'd2);
               run_in = t;
               phase_in = (byte_ff == t) ? PH_NORMAL : PH_SCAN;
            end
         end else if (nx == CH_STAR) begin
            pos_in = POS_W'(ip2 + 1'b1);
            run_in = c;
            if (byte_ff == c) phase_in = PH_RUN;
            else begin
               phase_in = PH_NORMAL; busy_in = 1'b1;
            end
         end else if (c != CH_DOT && byte_ff != c) begin
            done_in = 1'b1; val_in = 1'b0; phase_in = PH_NORMAL;
         end else begin
            pos_in = POS_W'(ip2); phase_in = PH_NORMAL;
         end
      end
   end
   // the step in progress owes another one
   assign sts.glob_busy = busy_in;

   // final verdict
   logic suf_ok, glob_ok;
   always_comb begin
      suf_ok = (seen_ff >= n);
      for (int k = 0; k < PATTERN_MAX; k++)
         if (k < int'(n) && recent_ff[k] != pbyte(word_ff, (POS_W+1)'(int'(n) - 1 - k)))
            suf_ok = 1'b0;
      if (done_ff) glob_ok = val_ff;
      else if (phase_ff == PH_SCAN) glob_ok = 1'b0;
      else if (pos_ff >= n) glob_ok = 1'b1;
      else glob_ok = (n >= POS_W'(2)) && (pos_ff == n - POS_W'(2))
         && pbyte(word_ff, (POS_W+1)'(pos_ff)) == CH_DOT
         && pbyte(word_ff, (POS_W+1)'(pos_ff) + 1'b1) == CH_STAR;
      case (mode_ff)
         MODE_LITERAL: verdict = eq_ff && (seen_ff == n);
         MODE_PREFIX:  verdict = eq_ff && (seen_ff >= n);
         MODE_SUFFIX:  verdict = suf_ok;
         default:      verdict = glob_ok;
      endcase
   end

   // per-string state
   always_ff @(posedge clock) begin
      if (reset || cmd.finish) begin
         pos_ff <= '0; phase_ff <= PH_NORMAL; run_ff <= '0;
         done_ff <= 1'b0; val_ff <= 1'b0; seen_ff <= '0; eq_ff <= 1'b1;
         busy_ff <= 1'b0; byte_ff <= '0;
         for (int k = 0; k < PATTERN_MAX; k++) recent_ff[k] <= '0;
      end else if (cmd.load) begin
         byte_ff <= in_byte;
         if (in_has) begin
            if (seen_ff < n && in_byte != pbyte(word_ff, (POS_W+1)'(seen_ff)))
               eq_ff <= 1'b0;
            if (seen_ff < POS_W'(PATTERN_MAX + 1)) seen_ff <= seen_ff + 1'b1;
            recent_ff[0] <= in_byte;
            for (int k = 1; k < PATTERN_MAX; k++) recent_ff[k] <= recent_ff[k-1];
         end
      end else if (cmd.glob_go) begin
         pos_ff <= pos_in; phase_ff <= phase_in; run_ff <= run_in;
         done_ff <= done_in; val_ff <= val_in; busy_ff <= busy_in;
      end
   end
endmodule

[design/gpsm_control.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// gpsm_control
// Sequencer: load byte, walk glob steps, then on a last item finish and present the result.
// ----------------------------------------------------------------------------
module gpsm_control import gpsm_pkg::*; (
   input  logic         clock,
   input  logic         reset,
   input  logic         req_valid,
   output logic         req_stall,
   input  logic         req_has_byte,
   input  logic         req_last,
   output logic         rsp_valid,
   input  logic         rsp_stall,
   output logic         rsp_matched,
   input  gpsm_sts_type sts,
   input  logic         verdict,
   output gpsm_cmd_type cmd
);
   typedef enum logic [1:0] {S_IDLE, S_GLOB, S_FINAL} state_type;
   state_type state_ff;
   logic has_ff, last_ff, out_v_ff, out_m_ff;

   logic accept;
   assign req_stall = (state_ff != S_IDLE);
   assign accept = req_valid && !req_stall;
   assign rsp_valid = out_v_ff;
   assign rsp_matched = out_m_ff;

   always_comb begin
      cmd = '0;
      cmd.load = accept;
      cmd.glob_go = (state_ff == S_GLOB) && has_ff;
      cmd.finish = (state_ff == S_FINAL) && !(out_v_ff && rsp_stall);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= S_IDLE; has_ff <= 1'b0; last_ff <= 1'b0;
         out_v_ff <= 1'b0; out_m_ff <= 1'b0;
      end else begin
         // result register: load on finish, free when taken
         if (cmd.finish) begin
            out_v_ff <= 1'b1; out_m_ff <= verdict;
         end else if (out_v_ff && !rsp_stall) begin
            out_v_ff <= 1'b0;
         end
         unique case (state_ff)
            S_IDLE: if (accept) begin
               has_ff <= req_has_byte; last_ff <= req_last;
               state_ff <= S_GLOB;
            end
            // stay while the glob walk owes another step
            S_GLOB: if (!(has_ff && sts.glob_busy)) begin
               state_ff <= last_ff ? S_FINAL : S_IDLE;
            end
            S_FINAL: if (cmd.finish) begin
               state_ff <= S_IDLE;
            end
            default: state_ff <= S_IDLE;
         endcase
      end
   end
endmodule

[design/glob_pattern_stream_matcher_unit.sv]
`timescale 1ns / 1ps
// An item is loaded, then walked by glob steps, a further step per pattern
// element crossed by empty star runs; a last item then finishes. Requests stall
// meanwhile. The single glob step unit walks one pattern element per cycle.
// The result register frees when taken; a final item waits while it is held.
// Reset (synchronous, active high) clears registers and per-string state.
// ----------------------------------------------------------------------------
// glob_pattern_stream_matcher_unit
// Streaming literal/prefix/suffix/glob matcher, up to one byte per transaction.
// ----------------------------------------------------------------------------
module glob_pattern_stream_matcher_unit import gpsm_pkg::*; (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_valid,
   output logic        req_stall,
   input  logic [7:0]  req_string_byte,
   input  logic        req_has_byte,
   input  logic        req_last,
   output logic        rsp_valid,
   input  logic        rsp_stall,
   output logic        rsp_matched,
   input  logic        csr_valid,
   output logic        csr_ready,
   input  logic [2:0]  csr_index,
   input  logic [63:0] csr_data
);
   gpsm_cmd_type cmd;
   gpsm_sts_type sts;
   logic verdict;
   assign csr_ready = 1'b1;

   gpsm_control u_ctl (
      .clock, .reset, .req_valid, .req_stall, .req_has_byte, .req_last,
      .rsp_valid, .rsp_stall, .rsp_matched, .sts, .verdict, .cmd
   );

   gpsm_datapath u_dp (
      .clock, .reset, .csr_we(csr_valid && csr_ready), .csr_index, .csr_data,
      .in_byte(req_string_byte), .in_has(req_has_byte), .cmd, .sts, .verdict
   );
endmodule

[design/gpsm_checker.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// gpsm_checker
// Port-level checks of the matcher.
// ----------------------------------------------------------------------------
`include "glob_pattern_stream_matcher_unit_defines.svh"
module gpsm_checker (
   input logic clock,
   input logic reset,
   input logic req_valid,
   input logic req_stall,
   input logic rsp_valid,
   input logic rsp_stall,
   input logic rsp_matched
);
   `GPSM_ASSERT_NXT(a_rsp_hold, clock, reset, rsp_valid && rsp_stall, rsp_valid && $stable(rsp_matched), "result dropped while stalled")
   `GPSM_ASSERT_NXT(a_busy_after, clock, reset, req_valid && !req_stall, req_stall, "item accepted without processing gap")
   `GPSM_ASSERT_IMP(a_rsp_cause, clock, reset, $rose(rsp_valid), $past(req_stall), "result without a pending item")
endmodule

bind glob_pattern_stream_matcher_unit gpsm_checker u_chk (
   .clock, .reset, .req_valid, .req_stall,
   .rsp_valid, .rsp_stall, .rsp_matched
);

[sim/glob_pattern_stream_matcher_unit_tb.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// glob_pattern_stream_matcher_unit_tb
// Self-checking bench for the stream matcher. A directed table exercises the
// reset state, each match mode, empty items, escapes and clamped lengths. It
// is followed by random phases that reprogram every register and stream
// strings built mostly from the pattern. Every verdict is checked against a
// local model of the matcher or a verdict given in the table. Both channels
// idle at random except in the closing stretch.
// ----------------------------------------------------------------------------
module glob_pattern_stream_matcher_unit_tb import gpsm_pkg::*;;

   typedef enum logic {ROW_CSR, ROW_ITEM} row_kind_type;
   typedef struct {
      row_kind_type kind;
      logic [2:0]  idx;
      logic [63:0] data;
      logic [7:0]  sbyte;
      logic        has;
      logic        fin;
      int          verdict;   // -1: take the model's verdict
   } stim_row_type;

   logic        clock = 0;
   logic        reset = 1;
   logic        req_valid = 0;
   logic        req_stall;
   logic [7:0]  req_string_byte = 0;
   logic        req_has_byte = 0;
   logic        req_last = 0;
   logic        rsp_valid;
   logic        rsp_stall = 0;
   logic        rsp_matched;
   logic        csr_valid = 0;
   logic        csr_ready;
   logic [2:0]  csr_index = 0;
   logic [63:0] csr_data = 0;

   glob_pattern_stream_matcher_unit dut (.*);

   always #6 clock = ~clock;

   // model: registers
   logic [1:0] cfg_mode;
   logic [5:0] cfg_len;
   logic [7:0] pat [32];
   // model: per-string state
   int         glob_pos;
   logic [1:0] glob_phase;
   logic [7:0] glob_run;
   bit         glob_done, glob_val;
   int         bytes_seen;
   bit         still_equal;
   logic [7:0] recent [32];

   bit         verdicts_q [$];
   int         mismatches = 0;
   int         items_sent = 0;
   bit         calm = 0;
   int         stall_left = 0;
   int         quiet_cycles = 0;

   function automatic int used_len();
      return (cfg_len > PATTERN_MAX) ? PATTERN_MAX : int'(cfg_len);
   endfunction

   function automatic logic [7:0] pat_byte(int i, int n);
      return (i >= 0 && i < n && i < 32) ? pat[i] : 8'h00;
   endfunction

   function automatic void clear_string();
      glob_pos = 0; glob_phase = PH_NORMAL; glob_run = 0;
      glob_done = 0; glob_val = 0; bytes_seen = 0; still_equal = 1;
      foreach (recent[k]) recent[k] = 0;
   endfunction

   // greedy glob walk for one subject byte
   function automatic void glob_step(logic [7:0] b);
      int n, ip;
      logic [7:0] c, nx, t;
      bit esc;
      n = used_len();
      if (glob_done) return;
      if (glob_phase == PH_RUN) begin
         if (b == glob_run) return;
         glob_phase = PH_NORMAL;
      end else if (glob_phase == PH_SCAN) begin
         if (b == glob_run) glob_phase = PH_NORMAL;
         return;
      end
      while (1) begin
         ip = glob_pos;
         if (ip >= n) begin glob_done = 1; glob_val = 0; return; end
         c = pat[ip];
         ip++;
         nx = pat_byte(ip, n);
         esc = (c == CH_ESC);
         if (esc) begin
            c = nx;
            ip++;
            nx = pat_byte(ip, n);
         end
         if (nx == CH_STAR) begin
            if (!esc && c == CH_DOT) begin
               if (ip + 1 >= n) begin glob_done = 1; glob_val = 1; return; end
               ip++;
               t = pat[ip];
               if (t == CH_ESC) begin
                  ip++;
                  t = pat_byte(ip, n);
               end
               ip++;
               glob_pos = ip;
               glob_run = t;
               glob_phase = (b == t) ? PH_NORMAL : PH_SCAN;
               return;
            end
            ip++;
            glob_pos = ip;
            glob_run = c;
            if (b == c) begin glob_phase = PH_RUN; return; end
            continue;
         end
         if (c != CH_DOT && b != c) begin glob_done = 1; glob_val = 0; return; end
         glob_pos = ip;
         return;
      end
   endfunction

   function automatic void track_byte(logic [7:0] b);
      int n;
      n = used_len();
      if (bytes_seen < n && b != pat[bytes_seen]) still_equal = 0;
      if (bytes_seen < PATTERN_MAX + 1) bytes_seen++;
      for (int k = 31; k > 0; k--) recent[k] = recent[k-1];
      recent[0] = b;
      glob_step(b);
   endfunction

   function automatic bit string_verdict();
      int n;
      n = used_len();
      case (cfg_mode)
         MODE_LITERAL: return still_equal && bytes_seen == n;
         MODE_PREFIX:  return still_equal && bytes_seen >= n;
         MODE_SUFFIX: begin
            if (bytes_seen < n) return 0;
            for (int k = 0; k < n; k++)
               if (recent[k] != pat[n-1-k]) return 0;
            return 1;
         end
         default: begin
            if (glob_done) return glob_val;
            if (glob_phase == PH_SCAN) return 0;
            if (glob_pos >= n) return 1;
            return n >= 2 && glob_pos == n - 2 && pat[glob_pos] == CH_DOT &&
                   pat[glob_pos+1] == CH_STAR;
         end
      endcase
   endfunction

   // result checking
   always @(posedge clock) begin
      if (!reset && rsp_valid && !rsp_stall) begin
         if (verdicts_q.size() == 0) begin
            mismatches++;
            if (mismatches <= 10) $display("unexpected verdict %0b", rsp_matched);
         end else begin
            bit want;
            want = verdicts_q.pop_front();
            if (rsp_matched !== want) begin
               mismatches++;
               if (mismatches <= 10)
                  $display("verdict mismatch: expected %0b got %0b", want, rsp_matched);
            end
         end
      end
   end

   // receiver stall bursts
   always @(posedge clock) begin
      if (reset || calm) rsp_stall <= 0;
      else if (stall_left > 0) begin
         stall_left--;
         rsp_stall <= 1;
      end else if ($urandom_range(0, 6) == 0) begin
         stall_left = $urandom_range(0, 7);
         rsp_stall <= 1;
      end else rsp_stall <= 0;
   end

   // watchdog on cycles with no transaction
   always @(posedge clock) begin
      if (reset || (req_valid && !req_stall) || (rsp_valid && !rsp_stall) ||
          (csr_valid && csr_ready))
         quiet_cycles <= 0;
      else if (quiet_cycles >= 20000) begin
         $display("[glob_pattern_stream_matcher_unit] ERROR");
         $finish;
      end else quiet_cycles <= quiet_cycles + 1;
   end

   task automatic csr_write(logic [2:0] idx, logic [63:0] data);
      csr_valid <= 1;
      csr_index <= idx;
      csr_data  <= data;
      do @(posedge clock); while (!csr_ready);
      case (idx)
         REG_MODE: cfg_mode = data[1:0];
         REG_LEN:  cfg_len  = data[5:0];
         REG_W0, REG_W1, REG_W2, REG_W3:
            for (int k = 0; k < 8; k++) pat[(idx - REG_W0) * 8 + k] = data[8*k +: 8];
         default: ;
      endcase
   endtask

   task automatic send_item(logic [7:0] b, logic has, logic fin, int typed);
      bit v;
      csr_valid <= 0;
      if (!calm && $urandom_range(0, 5) == 0) begin
         req_valid <= 0;
         repeat ($urandom_range(1, 8)) @(posedge clock);
      end
      req_valid       <= 1;
      req_string_byte <= b;
      req_has_byte    <= has;
      req_last        <= fin;
      do @(posedge clock); while (req_stall);
      if (has) track_byte(b);
      if (fin) begin
         v = string_verdict();
         if (typed >= 0) v = typed[0];
         verdicts_q.push_back(v);
         clear_string();
      end
      if (has || fin) items_sent++;
   endtask

   // idle the block: all verdicts back, then let any glob walk finish
   task automatic drain();
      req_valid <= 0;
      while (verdicts_q.size() != 0) @(posedge clock);
      repeat (40) @(posedge clock);
   endtask

   function automatic logic [7:0] glob_sym();
      case ($urandom_range(0, 8))
         0, 1: return "a";
         2:    return "b";
         3:    return "c";
         4, 5: return CH_DOT;
         6:    return CH_STAR;
         7:    return CH_ESC;
         default: return 8'($urandom);
      endcase
   endfunction

   function automatic logic [7:0] subj_sym();
      case ($urandom_range(0, 5))
         0, 1: return "a";
         2:    return "b";
         3:    return "c";
         default: return 8'($urandom);
      endcase
   endfunction

   stim_row_type dir_rows [] = '{
      // reset state: empty pattern, literal mode
      '{ROW_ITEM, 0, 0, 8'h00, 0, 1, 1},
      '{ROW_ITEM, 0, 0, 8'hFF, 1, 1, 0},
      '{ROW_CSR, REG_LEN, 64'd3, 0, 0, 0, -1},
      '{ROW_CSR, REG_W0, 64'h0000_0000_0063_6261, 0, 0, 0, -1},
      '{ROW_ITEM, 0, 0, "a", 1, 0, -1},
      '{ROW_ITEM, 0, 0, 8'h00, 0, 0, -1},     // empty item in mid-string
      '{ROW_ITEM, 0, 0, "b", 1, 0, -1},
      '{ROW_ITEM, 0, 0, "c", 1, 1, 1},
      '{ROW_CSR, REG_MODE, 64'(MODE_PREFIX), 0, 0, 0, -1},
      '{ROW_ITEM, 0, 0, "a", 1, 0, -1},
      '{ROW_ITEM, 0, 0, "b", 1, 0, -1},
      '{ROW_ITEM, 0, 0, "c", 1, 0, -1},
      '{ROW_ITEM, 0, 0, 8'hFF, 1, 1, 1},
      '{ROW_CSR, REG_MODE, 64'(MODE_SUFFIX), 0, 0, 0, -1},
      '{ROW_ITEM, 0, 0, 8'h00, 1, 0, -1},
      '{ROW_ITEM, 0, 0, "a", 1, 0, -1},
      '{ROW_ITEM, 0, 0, "b", 1, 0, -1},
      '{ROW_ITEM, 0, 0, "c", 1, 1, 1},
      '{ROW_ITEM, 0, 0, "b", 1, 1, 0},
      // glob with a trailing escape: "a.c*\"
      '{ROW_CSR, REG_MODE, 64'(MODE_GLOB), 0, 0, 0, -1},
      '{ROW_CSR, REG_LEN, 64'd5, 0, 0, 0, -1},
      '{ROW_CSR, REG_W0, 64'h0000_005C_2A63_2E61, 0, 0, 0, -1},
      '{ROW_ITEM, 0, 0, "a", 1, 0, -1},
      '{ROW_ITEM, 0, 0, "z", 1, 0, -1},
      '{ROW_ITEM, 0, 0, "c", 1, 0, -1},
      '{ROW_ITEM, 0, 0, "c", 1, 0, -1},
      '{ROW_ITEM, 0, 0, 8'h00, 1, 1, -1},
      // ".*z", then bytes past the pattern
      '{ROW_CSR, REG_LEN, 64'd3, 0, 0, 0, -1},
      '{ROW_CSR, REG_W0, 64'h0000_0000_007A_2A2E, 0, 0, 0, -1},
      '{ROW_ITEM, 0, 0, "q", 1, 0, -1},
      '{ROW_ITEM, 0, 0, "z", 1, 1, -1},
      '{ROW_ITEM, 0, 0, "z", 1, 0, -1},
      '{ROW_ITEM, 0, 0, "q", 1, 1, -1},
      // clamped length, literal of 32 zero bytes
      '{ROW_CSR, REG_MODE, 64'(MODE_LITERAL), 0, 0, 0, -1},
      '{ROW_CSR, REG_LEN, 64'd63, 0, 0, 0, -1},
      '{ROW_CSR, REG_W0, 64'h0, 0, 0, 0, -1},
      '{ROW_ITEM, 0, 0, 8'h00, 1, 1, 0}
   };

   initial begin
      logic [7:0] subj [$];
      logic [7:0] c;
      logic [63:0] w;
      int n;
      bit prev_item;
      cfg_mode = 0; cfg_len = 0;
      foreach (pat[k]) pat[k] = 0;
      clear_string();
      repeat (8) @(posedge clock);
      reset <= 0;
      @(posedge clock);

      prev_item = 0;
      foreach (dir_rows[r]) begin
         if (dir_rows[r].kind == ROW_CSR) begin
            if (prev_item) drain();
            csr_write(dir_rows[r].idx, dir_rows[r].data);
            prev_item = 0;
         end else begin
            send_item(dir_rows[r].sbyte, dir_rows[r].has, dir_rows[r].fin,
                      dir_rows[r].verdict);
            prev_item = 1;
         end
      end

      // random phases: reprogram everything, then stream a batch of strings
      while (items_sent < 900) begin
         drain();
         csr_write(REG_MODE, 64'($urandom_range(0, 3)));
         case ($urandom_range(0, 9))
            0:       n = $urandom_range(33, 63);
            1:       n = 32;
            2:       n = 0;
            default: n = $urandom_range(1, 9);
         endcase
         csr_write(REG_LEN, 64'(n));
         for (int wi = 0; wi < 4; wi++) begin
            for (int k = 0; k < 8; k++) w[8*k +: 8] = glob_sym();
            if ($urandom_range(0, 7) == 0) w = {$urandom, $urandom};
            csr_write(REG_W0 + 3'(wi), w);
         end
         if (items_sent > 780) calm = 1;
         repeat ($urandom_range(3, 10)) begin
            subj.delete();
            n = used_len();
            if ($urandom_range(0, 3) != 0) begin
               // shaped after the pattern, with some mutations
               for (int i = 0; i < n; i++) begin
                  c = pat[i];
                  if (c == CH_ESC) continue;
                  if (c == CH_STAR) begin
                     if (i > 0) repeat ($urandom_range(0, 3)) subj.push_back(pat[i-1]);
                     continue;
                  end
                  if (c == CH_DOT) c = subj_sym();
                  if ($urandom_range(0, 9) == 0) c = subj_sym();
                  subj.push_back(c);
               end
               if ($urandom_range(0, 4) == 0) subj.push_back(subj_sym());
               if ($urandom_range(0, 5) == 0 && subj.size() > 0)
                  subj.delete(subj.size() - 1);
            end else begin
               repeat ($urandom_range(0, ($urandom_range(0, 7) == 0) ? 40 : 10))
                  subj.push_back(subj_sym());
            end
            foreach (subj[i]) begin
               if ($urandom_range(0, 15) == 0) send_item(8'($urandom), 0, 0, -1);
               send_item(subj[i], 1, (i == subj.size() - 1) && $urandom_range(0, 4) != 0, -1);
            end
            if (subj.size() == 0 || !req_last)
               send_item(8'($urandom), 0, 1, -1);
         end
      end

      drain();
      if (mismatches == 0 && verdicts_q.size() == 0)
         $display("[glob_pattern_stream_matcher_unit] OK");
      else
         $display("[glob_pattern_stream_matcher_unit] ERROR");
      $finish;
   end
endmodule
